### rtl/wes_pkg.sv
`default_nettype none

package wes_pkg;

	// Configuration register widths and the write port's data width
	localparam int CFG_DIM_W   = 11;
	localparam int CFG_COEFF_W = 24;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_IDX_W   = 2;

	// Fraction bits of the Courant coefficient (unsigned Q8.16)
	localparam int COEFF_FRAC = 16;

	// Register values after reset
	localparam logic [CFG_DIM_W-1:0]   GRID_WIDTH_RST    = CFG_DIM_W'(100);
	localparam logic [CFG_DIM_W-1:0]   GRID_HEIGHT_RST   = CFG_DIM_W'(100);
	localparam logic [CFG_COEFF_W-1:0] COURANT_COEFF_RST = CFG_COEFF_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_WIDTH    = 2'd0,
		CFG_GRID_HEIGHT   = 2'd1,
		CFG_COURANT_COEFF = 2'd2
	} cfg_idx_t;

	// Per-item control flags that travel with an item through the first stage
	typedef struct packed {
		logic emit;       // a result is produced for this item
		logic last;       // final grid point of the step
		logic first_row;  // row 0: upper store is loaded with zero
		logic col_zero;   // left neighbour is outside the grid
		logic right_en;   // right neighbour is inside the grid
	} s1_ctrl_t;

endpackage

`default_nettype wire

### rtl/wave_equation_stencil_step.sv
// Leapfrog time step of the 2D wave equation on a five-point stencil.
// Input channel (in_valid/in_stall): one transaction per grid point in raster
// order, carrying cur_sample and old_sample (signed Q3.20). After grid_height
// rows, send grid_width drain transactions (flush); they read as zero.
// Output channel (out_valid/out_stall): one transaction with new_sample per
// grid point, one row behind the input; the first input row yields nothing.
// last marks the final grid point of the step. Results saturate.
// A result enters the output register by way of the stage 1 register, once
// the transaction that completes its stencil is taken. Throughput: one
// transaction per cycle while the receiver does not stall, set by the single
// stencil update stage and the row stores, written and read once per item.
// When the receiver stalls, the output register holds; the stage in front
// of it holds too, so input stalls only when both are full.
// Reset (arst_n low) returns the row/column counters to the grid start and
// loads the registers with a 100x100 grid and a coefficient of 1.0. Row
// stores are not cleared. Write configuration only while the block is idle.
`default_nettype none

module wave_equation_stencil_step #(
	parameter int MAX_WIDTH = 1024,
	parameter int FRAC_BITS = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [wes_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wes_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [FRAC_BITS+3:0]         cur_sample,
	input  logic signed [FRAC_BITS+3:0]         old_sample,
	input  logic                                flush,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [FRAC_BITS+3:0]         new_sample,
	output logic                                last
);
	import wes_pkg::*;

	localparam int SAMPLE_W = FRAC_BITS + 4;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int WEFF_W   = $clog2(MAX_WIDTH + 1);
	// four neighbours minus four times the centre fit in three extra bits; four are used
	localparam int LAP_W    = SAMPLE_W + 4;
	localparam int PROD_W   = LAP_W + CFG_COEFF_W + 1;
	localparam logic signed [PROD_W-1:0] SAT_HI =
		PROD_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
	localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);
	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (COEFF_FRAC - 1);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [CFG_DIM_W-1:0]   grid_width_q;
	logic [CFG_DIM_W-1:0]   grid_height_q;
	logic [CFG_COEFF_W-1:0] courant_coeff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q    <= GRID_WIDTH_RST;
			grid_height_q   <= GRID_HEIGHT_RST;
			courant_coeff_q <= COURANT_COEFF_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_GRID_WIDTH:    grid_width_q    <= cfg_data[CFG_DIM_W-1:0];
				CFG_GRID_HEIGHT:   grid_height_q   <= cfg_data[CFG_DIM_W-1:0];
				CFG_COURANT_COEFF: courant_coeff_q <= cfg_data[CFG_COEFF_W-1:0];
				default: ;  // index with no register: drop the write
			endcase
		end
	end

	// Effective sizes: zero taken as one, width clipped to the store depth
	logic [WEFF_W-1:0]    w_eff;
	logic [CFG_DIM_W-1:0] h_eff;

	always_comb begin
		if (grid_width_q == '0)
			w_eff = WEFF_W'(1);
		else if (32'(grid_width_q) > 32'(MAX_WIDTH))
			w_eff = WEFF_W'(MAX_WIDTH);
		else
			w_eff = WEFF_W'(grid_width_q);
		h_eff = (grid_height_q == '0) ? CFG_DIM_W'(1) : grid_height_q;
	end

	// ---------------------------------------------------------------
	// Raster position of the item at the input
	// ---------------------------------------------------------------
	logic [COL_W-1:0]     col_cnt_q;
	logic [CFG_DIM_W-1:0] row_cnt_q;
	logic [COL_W-1:0]     col;
	logic [WEFF_W-1:0]    col_p1;
	logic [COL_W-1:0]     right_addr;
	logic [CFG_DIM_W-1:0] row;
	logic                 drain;
	logic                 right_en;
	logic                 in_acc;
	logic signed [SAMPLE_W-1:0] c_in;
	logic signed [SAMPLE_W-1:0] o_in;
	s1_ctrl_t             ctrl_in;

	always_comb begin
		// a count beyond a shrunk size is taken as the last column / drain row
		if (WEFF_W'(col_cnt_q) < w_eff)
			col = col_cnt_q;
		else
			col = COL_W'(w_eff - WEFF_W'(1));
		row        = (row_cnt_q <= h_eff) ? row_cnt_q : h_eff;
		drain      = (row == h_eff);
		col_p1     = WEFF_W'(col) + WEFF_W'(1);
		right_en   = (col_p1 < w_eff);
		right_addr = right_en ? col_p1[COL_W-1:0] : '0;

		// drain items and flushed grid items carry zero samples
		if (drain || flush) begin
			c_in = '0;
			o_in = '0;
		end else begin
			c_in = cur_sample;
			o_in = old_sample;
		end

		ctrl_in.emit      = (row != '0);
		ctrl_in.last      = drain && !right_en;
		ctrl_in.first_row = (row == '0);
		ctrl_in.col_zero  = (col == '0);
		ctrl_in.right_en  = right_en;
	end

	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (in_acc) begin
			if (right_en) begin
				col_cnt_q <= col_p1[COL_W-1:0];
				row_cnt_q <= row;
			end else begin
				// wrap to the next row; after the drain row, back to the top
				col_cnt_q <= '0;
				row_cnt_q <= drain ? '0 : row + CFG_DIM_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Row stores. Middle and old are written as the item is taken and
	// read old-data-first, so a read sees the previous row. The upper
	// store is written when the item leaves stage 1.
	// ---------------------------------------------------------------
	logic signed [SAMPLE_W-1:0] middle_row_store [MAX_WIDTH];
	logic signed [SAMPLE_W-1:0] old_row_store    [MAX_WIDTH];
	logic signed [SAMPLE_W-1:0] upper_row_store  [MAX_WIDTH];

	logic signed [SAMPLE_W-1:0] center_s1;
	logic signed [SAMPLE_W-1:0] right_s1;
	logic signed [SAMPLE_W-1:0] old_s1;
	logic signed [SAMPLE_W-1:0] up_raw_s1;

	logic                       s1_adv;
	logic                       up_we;
	logic [COL_W-1:0]           col_s1;
	logic signed [SAMPLE_W-1:0] up_wdata;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			center_s1               <= middle_row_store[col];
			right_s1                <= middle_row_store[right_addr];
			middle_row_store[col]   <= c_in;
			old_s1                  <= old_row_store[col];
			old_row_store[col]      <= o_in;
		end
	end

	always_ff @(posedge clk) begin
		if (up_we)
			upper_row_store[col_s1] <= up_wdata;
		if (in_acc)
			up_raw_s1 <= upper_row_store[col];
	end

	// ---------------------------------------------------------------
	// Stage 1: item register alongside the store read data
	// ---------------------------------------------------------------
	logic                       s1_valid_q;
	s1_ctrl_t                   ctrl_s1;
	logic signed [SAMPLE_W-1:0] c_in_s1;
	logic                       up_fwd_s1;
	logic signed [SAMPLE_W-1:0] up_fwd_data_s1;
	logic signed [SAMPLE_W-1:0] left_q;
	logic                       s2_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (in_acc)
			s1_valid_q <= 1'b1;
		else if (s1_adv)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ctrl_s1        <= ctrl_in;
			col_s1         <= col;
			c_in_s1        <= c_in;
			// upper entry being written this very edge: take the new data
			up_fwd_s1      <= up_we && (col_s1 == col);
			up_fwd_data_s1 <= up_wdata;
		end
	end

	// left neighbour is the centre of the item that went before
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			left_q <= '0;
		else if (s1_adv)
			left_q <= center_s1;
	end

	assign s1_adv   = s1_valid_q && (!s2_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !s1_adv;
	assign up_we    = s1_adv;
	assign up_wdata = ctrl_s1.first_row ? '0 : center_s1;

	// Stencil update
	logic signed [SAMPLE_W-1:0]    up_v;
	logic signed [SAMPLE_W-1:0]    left_v;
	logic signed [SAMPLE_W-1:0]    right_v;
	logic signed [LAP_W-1:0]       lap;
	logic signed [CFG_COEFF_W:0]   coeff_s;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W-1:0]      step;
	logic signed [PROD_W-1:0]      res;
	logic signed [SAMPLE_W-1:0]    res_sat;

	always_comb begin
		up_v    = up_fwd_s1 ? up_fwd_data_s1 : up_raw_s1;
		left_v  = ctrl_s1.col_zero ? '0 : left_q;
		right_v = ctrl_s1.right_en ? right_s1 : '0;
		lap     = LAP_W'(up_v) + LAP_W'(c_in_s1) + LAP_W'(left_v) + LAP_W'(right_v)
		          - (LAP_W'(center_s1) <<< 2);
		coeff_s = {1'b0, courant_coeff_q};
		prod    = PROD_W'(coeff_s * lap);
		// round half up, then floor shift back to the sample format
		step    = (prod + RND_HALF) >>> COEFF_FRAC;
		res     = (PROD_W'(center_s1) <<< 1) - PROD_W'(old_s1) + step;
		if (res > SAT_HI)
			res_sat = SAT_HI[SAMPLE_W-1:0];
		else if (res < SAT_LO)
			res_sat = SAT_LO[SAMPLE_W-1:0];
		else
			res_sat = res[SAMPLE_W-1:0];
	end

	// ---------------------------------------------------------------
	// Stage 2: output register
	// ---------------------------------------------------------------
	logic signed [SAMPLE_W-1:0] new_sample_s2;
	logic                       last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_valid_q <= 1'b0;
		else if (s1_adv)
			s2_valid_q <= ctrl_s1.emit;
		else if (!out_stall)
			s2_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv && ctrl_s1.emit) begin
			new_sample_s2 <= res_sat;
			last_s2       <= ctrl_s1.last;
		end
	end

	assign out_valid  = s2_valid_q;
	assign new_sample = new_sample_s2;
	assign last       = last_s2;

`ifndef NO_ASSERTIONS
	// input is held back only while both stages are full and output stalls
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid && out_stall))
		else $error("input stalled with room in the pipeline");

	// the step's final point lies in a row that produces results
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && ctrl_s1.last) |-> ctrl_s1.emit)
		else $error("last flag on an item without a result");

	// a new result only comes out of an occupied first stage
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(s1_valid_q))
		else $error("result appeared without an item in stage 1");

	// the end of the drain row returns the raster position to the top
	a_step_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && drain && !right_en) |=> (row_cnt_q == '0 && col_cnt_q == '0))
		else $error("counters did not wrap after the drain row");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_cnt_q) < 32'(MAX_WIDTH))
		else $error("column counter beyond the row store depth");
`endif

endmodule

`default_nettype wire

### tb/wes_stencil_checker.sv
`default_nettype none

module wes_stencil_checker #(
	parameter int MAX_WIDTH = 1024,
	parameter int FRAC_BITS = 20
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [wes_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [wes_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	input  wire logic                            in_stall,
	input  wire logic signed [FRAC_BITS+3:0]     cur_sample,
	input  wire logic signed [FRAC_BITS+3:0]     old_sample,
	input  wire logic                            flush,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic signed [FRAC_BITS+3:0]     new_sample,
	input  wire logic                            last,
	output int                                   fail_count,
	output int                                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import wes_pkg::*;

	localparam int SAMPLE_W = FRAC_BITS + 4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct {
		sample_t sample;
		logic    last_flag;
	} grid_result_t;

	logic [CFG_DIM_W-1:0]   width_reg;
	logic [CFG_DIM_W-1:0]   height_reg;
	logic [CFG_COEFF_W-1:0] coeff_reg;

	sample_t upper_line [MAX_WIDTH];
	sample_t middle_line [MAX_WIDTH];
	sample_t old_line [MAX_WIDTH];
	int unsigned col_cnt;
	int unsigned row_cnt;
	sample_t left_val;

	grid_result_t next_levels [$];
	int mismatches;

	// advance the stencil by one grid point and queue its result, if any
	task automatic advance_stencil(input sample_t cur_in, input sample_t old_in, input logic fl);
		int unsigned w, h, col, row;
		bit drain;
		sample_t c, o;
		longint up_l, ctr_l, left_l, right_l, old_l, c_l, coeff_l;
		longint lap, prod, upd, total, hi, lo;
		grid_result_t pt;
		w = width_reg;
		if (w == 0) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		h = height_reg;
		if (h == 0) h = 1;
		col = (col_cnt < w) ? col_cnt : w - 1;
		row = (row_cnt <= h) ? row_cnt : h;
		drain = (row == h);
		if (drain || fl) begin
			c = '0;
			o = '0;
		end else begin
			c = cur_in;
			o = old_in;
		end
		if (row >= 1) begin
			up_l = upper_line[col];
			ctr_l = middle_line[col];
			left_l = (col == 0) ? 0 : left_val;
			right_l = 0;
			if (col + 1 < w) right_l = middle_line[col+1];
			old_l = old_line[col];
			c_l = c;
			coeff_l = coeff_reg;
			lap = up_l + c_l + left_l + right_l - 4 * ctr_l;
			prod = coeff_l * lap;
			upd = (prod + (64'sd1 <<< (COEFF_FRAC - 1))) >>> COEFF_FRAC;
			total = 2 * ctr_l - old_l + upd;
			hi = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
			lo = -hi - 1;
			if (total > hi) total = hi;
			if (total < lo) total = lo;
			pt.sample = total[SAMPLE_W-1:0];
			pt.last_flag = drain && (col == w - 1);
			next_levels.push_back(pt);
		end
		left_val = middle_line[col];
		upper_line[col] = (row == 0) ? '0 : middle_line[col];
		middle_line[col] = c;
		old_line[col] = o;
		if (col + 1 < w) begin
			col_cnt = col + 1;
			row_cnt = row;
		end else begin
			col_cnt = 0;
			row_cnt = drain ? 0 : row + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		grid_result_t pt;
		if (!arst_n) begin
			width_reg = GRID_WIDTH_RST;
			height_reg = GRID_HEIGHT_RST;
			coeff_reg = COURANT_COEFF_RST;
			col_cnt = 0;
			row_cnt = 0;
			left_val = '0;
			next_levels.delete();
			mismatches = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (next_levels.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result new_sample=%0d last=%0b",
							$realtime, new_sample, last);
					mismatches++;
				end else begin
					pt = next_levels.pop_front();
					if (new_sample !== pt.sample || last !== pt.last_flag) begin
						if (mismatches < 10)
							$display("%0t: new_sample exp %0d got %0d, last exp %0b got %0b",
								$realtime, pt.sample, new_sample, pt.last_flag, last);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				advance_stencil(cur_sample, old_sample, flush);
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
					CFG_GRID_WIDTH: width_reg = cfg_data[CFG_DIM_W-1:0];
					CFG_GRID_HEIGHT: height_reg = cfg_data[CFG_DIM_W-1:0];
					CFG_COURANT_COEFF: coeff_reg = cfg_data[CFG_COEFF_W-1:0];
					default: ;
				endcase
			end
			pending <= next_levels.size();
			fail_count <= mismatches;
		end
	end

endmodule

`default_nettype wire

### tb/tb_wave_equation_stencil_step.sv
`default_nettype none

module tb_wave_equation_stencil_step;
	timeunit 1ns;
	timeprecision 1ps;

	import wes_pkg::*;

	localparam int MAX_WIDTH   = 1024;
	localparam int FRAC_BITS   = 20;
	localparam int SAMPLE_W    = FRAC_BITS + 4;
	localparam int RANDOM_POINTS = 1450;
	// Longest correct quiet stretch is the receiver hold-off plus a sender
	// gap; allow several times that.
	localparam int QUIET_LIMIT = 5000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// How the sample values of one time step are drawn
	typedef enum {FILL_EXTREME, FILL_GENTLE, FILL_FULL, FILL_MIXED} fill_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	sample_t                 cur_sample;
	sample_t                 old_sample;
	logic                    flush;
	logic                    out_valid;
	logic                    out_stall;
	sample_t                 new_sample;
	logic                    last;

	int fail_count;
	int pending;
	int quiet_cycles;
	int points_sent;
	bit sender_eager;

	wave_equation_stencil_step #(
		.MAX_WIDTH(MAX_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cur_sample(cur_sample),
		.old_sample(old_sample),
		.flush(flush),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.new_sample(new_sample),
		.last(last)
	);

	wes_stencil_checker #(
		.MAX_WIDTH(MAX_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cur_sample(cur_sample),
		.old_sample(old_sample),
		.flush(flush),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.new_sample(new_sample),
		.last(last),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #6 clk = ~clk;

	// Idle length: mostly back to back, sometimes a few cycles, rarely long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic sample_t pick_sample(fill_t f);
		fill_t g;
		g = f;
		if (g == FILL_MIXED) g = fill_t'($urandom_range(0, 2));
		case (g)
			FILL_EXTREME: begin
				case ($urandom_range(0, 5))
					0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
					1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
					2: return '0;
					3: return '1;
					4: return sample_t'(1);
					default: return sample_t'($urandom);
				endcase
			end
			// smooth-ish field around zero, keeps most results off the rails
			FILL_GENTLE: return sample_t'(int'($urandom_range(0, 524288)) - 262144);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_COEFF_W-1:0] pick_coeff();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return COURANT_COEFF_RST;
			3, 4, 5: return CFG_COEFF_W'($urandom_range(0, 131072));
			default: return CFG_COEFF_W'($urandom);
		endcase
	endfunction

	// Offer one transaction; call and return at a rising edge. Stall is
	// sampled at the falling edge, where it is settled.
	task automatic send_point(input sample_t c, input sample_t o, input logic fl);
		int gap;
		gap = sender_eager ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cur_sample <= c;
		old_sample <= o;
		flush <= fl;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		points_sent++;
	endtask

	// Program the three registers back to back, then stream one whole time
	// step: the grid rows and one drain row. Return once every result is in.
	task automatic run_step(input int w, input int h, input logic [CFG_COEFF_W-1:0] coeff,
			input fill_t f, input int flush_pct);
		int w_eff, h_eff;
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_GRID_WIDTH;
		// junk above bit 10 must be dropped by the register
		cfg_data <= {CFG_DATA_W'($urandom) << CFG_DIM_W} | CFG_DATA_W'(w);
		@(posedge clk);
		cfg_index <= CFG_GRID_HEIGHT;
		cfg_data <= CFG_DATA_W'(h);
		@(posedge clk);
		cfg_index <= CFG_COURANT_COEFF;
		cfg_data <= coeff;
		@(posedge clk);
		cfg_wr_en <= 1'b0;

		w_eff = w % (1 << CFG_DIM_W);
		if (w_eff == 0) w_eff = 1;
		if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
		h_eff = (h == 0) ? 1 : h;
		sender_eager = ($urandom_range(0, 3) == 0);

		for (int r = 0; r < h_eff; r++)
			for (int c = 0; c < w_eff; c++)
				send_point(pick_sample(f), pick_sample(f), $urandom_range(0, 99) < flush_pct);
		// drain row: the flush bit is ignored here, so vary it
		for (int c = 0; c < w_eff; c++)
			send_point(pick_sample(FILL_FULL), pick_sample(FILL_FULL), $urandom_range(0, 3) != 0);
		in_valid <= 1'b0;

		// hold until the last result is out, then let the pipe settle
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Receiver: random stall runs, stretches of free flow, and one long
	// hold-off so that both pipeline stages fill and input stalls.
	initial begin
		int len, rx_cycles, r;
		bit held_off, stall_now;
		rx_cycles = 0;
		held_off = 0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && rx_cycles > 1000) begin
				stall_now = 1'b1;
				len = 600;
				held_off = 1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					stall_now = 1'b0;
					len = $urandom_range(50, 200);
				end else if (r < 55) begin
					stall_now = 1'b0;
					len = $urandom_range(1, 4);
				end else begin
					stall_now = 1'b1;
					len = pick_gap();
					if (len == 0) len = 1;
				end
			end
			out_stall <= stall_now;
			repeat (len) @(posedge clk);
			rx_cycles += len;
		end
	end

	// Stimulus and verdict
	initial begin
		int w, h, r, random_start;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_GRID_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		cur_sample = '0;
		old_sample = '0;
		flush = 1'b0;
		points_sent = 0;
		sender_eager = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: rail values with the largest coefficient, zero sizes taken
		// as one, a single column, and flushed points inside the grid.
		run_step(3, 2, '1, FILL_EXTREME, 0);
		run_step(0, 0, '0, FILL_FULL, 0);
		run_step(1, 3, COURANT_COEFF_RST, FILL_EXTREME, 30);
		run_step(4, 1, CFG_COEFF_W'(1), FILL_EXTREME, 50);

		// A tall single-column grid
		run_step(1, 40, pick_coeff(), FILL_GENTLE, 2);

		// Random steps, mostly small grids
		random_start = points_sent;
		while (points_sent - random_start < RANDOM_POINTS) begin
			r = $urandom_range(0, 99);
			if (r < 10) w = $urandom_range(0, 1);
			else if (r < 75) w = $urandom_range(2, 8);
			else if (r < 95) w = $urandom_range(9, 40);
			else w = $urandom_range(41, 70);
			r = $urandom_range(0, 99);
			if (w > 40) h = $urandom_range(1, 3);
			else if (r < 10) h = $urandom_range(0, 1);
			else if (r < 85) h = $urandom_range(2, 6);
			else h = $urandom_range(7, 20);
			r = $urandom_range(0, 3);
			run_step(w, h, pick_coeff(), fill_t'($urandom_range(0, 3)),
				(r == 0) ? 30 : (r == 1) ? 5 : 0);
		end

		// run_step has already drained; allow a few more cycles for strays
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
rtl/wes_pkg.sv
rtl/wave_equation_stencil_step.sv
tb/wes_stencil_checker.sv
tb/tb_wave_equation_stencil_step.sv
